// ===== hw/rtl/slc_pkg.sv =====
// Shared types, codes and helper functions for the source line classifier.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package slc_pkg;

  // Marker sizes: the byte window always holds four bytes.
  localparam int MARK_BYTES = 4;
  localparam logic [2:0] MARK_LEN_MAX = 3'((MARK_BYTES < 4) ? MARK_BYTES : 4);

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_NUL     = 8'h00;

  // Result codes on line_class
  localparam logic [1:0] CLASS_BLANK   = 2'd0;
  localparam logic [1:0] CLASS_COMMENT = 2'd1;
  localparam logic [1:0] CLASS_CODE    = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_MARK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_MARK_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MARK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MARK_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_MARK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_MARK_LEN = 3'd5;

  // Per-line scan phase
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_CLOSE = 3'd1,
    PH_SCAN  = 3'd2,
    PH_HOLD  = 3'd3,
    PH_OPEN  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [31:0] line_mark;
    logic [2:0]  line_mark_len;
    logic [31:0] open_mark;
    logic [2:0]  open_mark_len;
    logic [31:0] close_mark;
    logic [2:0]  close_mark_len;
  } cfg_t;

  typedef struct packed {
    logic [31:0] byte_window;
    logic        in_block;
    phase_t      scan_phase;
    logic [2:0]  bytes_since_mark;
    logic        line_prefix_ok;
    logic        line_has_text;
    logic        line_is_comment;
    logic [2:0]  after_open;
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] cnt;
    logic       ok;
  } pfx_t;

  function automatic logic [2:0] clamp_len(input logic [2:0] v);
    return (v > MARK_LEN_MAX) ? MARK_LEN_MAX : v;
  endfunction

  function automatic logic [2:0] sat_inc(input logic [2:0] x);
    return (x == 3'd7) ? x : x + 3'd1;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Compare the newest len bytes of the window with the first len marker bytes.
  function automatic logic tail_match(input logic [31:0] win, input logic [31:0] mark,
                                      input logic [2:0] len);
    logic [31:0] mask;
    logic [31:0] shifted;
    logic [2:0]  drop;
    drop    = 3'd4 - len;
    shifted = win >> {drop, 3'b000};
    mask    = (len >= 3'd4) ? '1 : ((32'd1 << {len, 3'b000}) - 32'd1);
    return (shifted & mask) == (mark & mask);
  endfunction

  // One step of the line marker check at the start of a search region.
  function automatic pfx_t prefix_step(input logic [2:0] k, input logic ok,
                                       input logic [7:0] b, input logic [2:0] ll,
                                       input logic [31:0] mark);
    pfx_t       r;
    logic [7:0] mb;
    r.cnt = sat_inc(k);
    r.ok  = ok;
    r.hit = 1'b0;
    mb    = 8'(mark >> {k, 3'b000});
    if (ll == 3'd0) begin
      r.ok = 1'b0;
    end else if (ok && (k < ll)) begin
      if (b != mb) begin
        r.ok = 1'b0;
      end else if ((4'(k) + 4'd1) == 4'(ll)) begin
        r.hit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/slc_step.sv =====
// Next-state logic for one text byte: marker matching and line classification.
// Depends on slc_pkg.
module slc_step (
  input  slc_pkg::state_t state,
  input  slc_pkg::cfg_t   cfg,
  input  logic [7:0]      text_byte,
  input  logic            file_last,
  output slc_pkg::state_t state_next,
  output logic            emit,
  output logic [1:0]      line_class
);

  logic [31:0]      win;
  logic             inb;
  slc_pkg::phase_t  ph;
  logic [2:0]       bsm;
  logic             lpo;
  logic             lht;
  logic             lic;
  logic [2:0]       ao;
  logic [2:0]       ll;
  logic [2:0]       ol;
  logic [2:0]       cl;
  logic             om;
  logic             cm;
  logic             run_scan;
  logic             run_hold;
  logic             run_close;
  slc_pkg::pfx_t    p;

  always_comb begin
    win = {text_byte, state.byte_window[31:8]};
    inb = state.in_block;
    ph  = state.scan_phase;
    bsm = state.bytes_since_mark;
    lpo = state.line_prefix_ok;
    lht = state.line_has_text;
    lic = state.line_is_comment;
    ao  = state.after_open;
    ll  = slc_pkg::clamp_len(cfg.line_mark_len);
    ol  = slc_pkg::clamp_len(cfg.open_mark_len);
    cl  = slc_pkg::clamp_len(cfg.close_mark_len);
    if (cl == 3'd0) begin
      cl = 3'd1;
    end
    om = slc_pkg::tail_match(win, cfg.open_mark, ol);
    cm = slc_pkg::tail_match(win, cfg.close_mark, cl);
    run_scan  = 1'b0;
    run_hold  = 1'b0;
    run_close = 1'b0;
    p = '0;
    line_class = slc_pkg::CLASS_BLANK;

    // Phase dispatch
    if (ph == slc_pkg::PH_LEAD) begin
      if (slc_pkg::is_space(text_byte)) begin
        ph = slc_pkg::PH_LEAD;
      end else if (text_byte == slc_pkg::BYTE_NUL) begin
        ph = slc_pkg::PH_DONE;
      end else begin
        lht = 1'b1;
        if (inb) begin
          lic       = 1'b1;
          ph        = slc_pkg::PH_CLOSE;
          bsm       = 3'd0;
          run_close = 1'b1;
        end else begin
          ph       = slc_pkg::PH_SCAN;
          bsm      = 3'd0;
          lpo      = 1'b1;
          run_scan = 1'b1;
        end
      end
    end else if (ph != slc_pkg::PH_DONE) begin
      if (text_byte == slc_pkg::BYTE_NUL) begin
        if (ph == slc_pkg::PH_HOLD) begin
          inb = 1'b1;
        end
        ph = slc_pkg::PH_DONE;
      end else begin
        unique case (ph)
          slc_pkg::PH_CLOSE: run_close = 1'b1;
          slc_pkg::PH_SCAN:  run_scan  = 1'b1;
          slc_pkg::PH_HOLD:  run_hold  = 1'b1;
          slc_pkg::PH_OPEN: begin
            ao = slc_pkg::sat_inc(ao);
            if ((ao >= cl) && cm) begin
              inb = 1'b0;
              ph  = slc_pkg::PH_DONE;
            end
          end
          default: ph = slc_pkg::PH_DONE;
        endcase
      end
    end

    // Inside a block: look for the close marker
    if (run_close) begin
      bsm = slc_pkg::sat_inc(bsm);
      if ((bsm >= cl) && cm) begin
        inb = 1'b0;
        ph  = slc_pkg::PH_SCAN;
        bsm = 3'd0;
        lpo = 1'b1;
      end
    end

    // Fresh region or open marker awaiting the line marker verdict
    if (run_scan || run_hold) begin
      p   = slc_pkg::prefix_step(bsm, lpo, text_byte, ll, cfg.line_mark);
      bsm = p.cnt;
      lpo = p.ok;
      if (run_scan) begin
        if (p.hit) begin
          lic = 1'b1;
          ph  = slc_pkg::PH_DONE;
        end else if ((ol != 3'd0) && (bsm >= ol) && om) begin
          lic = 1'b1;
          ao  = 3'd0;
          if (lpo) begin
            ph = slc_pkg::PH_HOLD;
          end else begin
            ph  = slc_pkg::PH_OPEN;
            inb = 1'b1;
          end
        end
      end else begin
        if (p.hit) begin
          ph = slc_pkg::PH_DONE;
        end else begin
          ao = slc_pkg::sat_inc(ao);
          if ((ao >= cl) && cm) begin
            ph = slc_pkg::PH_DONE;
          end else if (!lpo) begin
            ph  = slc_pkg::PH_OPEN;
            inb = 1'b1;
          end
        end
      end
    end

    // End of line: classify and clear per-line state
    emit = (text_byte == slc_pkg::BYTE_NEWLINE) || file_last;
    if (emit) begin
      if (ph == slc_pkg::PH_HOLD) begin
        inb = 1'b1;
      end
      line_class = !lht ? slc_pkg::CLASS_BLANK :
                   (lic ? slc_pkg::CLASS_COMMENT : slc_pkg::CLASS_CODE);
      ph  = slc_pkg::PH_LEAD;
      bsm = 3'd0;
      lpo = 1'b1;
      lht = 1'b0;
      lic = 1'b0;
      ao  = 3'd0;
      if (file_last) begin
        inb = 1'b0;
        win = '0;
      end
    end

    state_next.byte_window      = win;
    state_next.in_block         = inb;
    state_next.scan_phase       = ph;
    state_next.bytes_since_mark = bsm;
    state_next.line_prefix_ok   = lpo;
    state_next.line_has_text    = lht;
    state_next.line_is_comment  = lic;
    state_next.after_open       = ao;
  end

endmodule

// ===== hw/rtl/source_line_classifier.sv =====
// Top level of the source line classifier: input register, state, result register.
// Depends on slc_pkg and slc_step.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  text_byte, file_last
//   out      source     out_valid/out_stall  line_class, file_end
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained, unless a line end waits on a full result register:
// the whole per-byte update (window shift, marker compares, phase change) is one
// pass of slc_step between the input register and the state/result registers.
// Synchronous active-high reset clears control state and loads default markers.
// A stall on out holds only bytes that end a line; other bytes keep flowing
// while a result waits. cfg_ready is always high.
module source_line_classifier (
  input  logic                           clk,
  input  logic                           rst,
  // byte stream
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     text_byte,
  input  logic                           file_last,
  // line results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     line_class,
  output logic                           file_end,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  slc_pkg::cfg_t   cfg;
  slc_pkg::state_t state;
  slc_pkg::state_t state_next;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  logic       emit;
  logic [1:0] class_next;
  logic       out_free;
  logic       s1_move;
  logic       accept;

  slc_step u_step (
    .state      (state),
    .cfg        (cfg),
    .text_byte  (s1_byte),
    .file_last  (s1_last),
    .state_next (state_next),
    .emit       (emit),
    .line_class (class_next)
  );

  // Advance the held byte unless it ends a line and the result register is full.
  assign out_free  = !out_valid || !out_stall;
  assign s1_move   = s1_valid && (!emit || out_free);
  assign in_stall  = s1_valid && !s1_move;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers: take a transaction in any cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_mark      <= 32'h0000_2F2F;
      cfg.line_mark_len  <= 3'd2;
      cfg.open_mark      <= 32'h0000_2A2F;
      cfg.open_mark_len  <= 3'd2;
      cfg.close_mark     <= 32'h0000_2F2A;
      cfg.close_mark_len <= 3'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slc_pkg::REG_LINE_MARK:      cfg.line_mark      <= cfg_data;
        slc_pkg::REG_LINE_MARK_LEN:  cfg.line_mark_len  <= cfg_data[2:0];
        slc_pkg::REG_OPEN_MARK:      cfg.open_mark      <= cfg_data;
        slc_pkg::REG_OPEN_MARK_LEN:  cfg.open_mark_len  <= cfg_data[2:0];
        slc_pkg::REG_CLOSE_MARK:     cfg.close_mark     <= cfg_data;
        slc_pkg::REG_CLOSE_MARK_LEN: cfg.close_mark_len <= cfg_data[2:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Scan state: advance once per byte that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.byte_window      <= '0;
      state.in_block         <= 1'b0;
      state.scan_phase       <= slc_pkg::PH_LEAD;
      state.bytes_since_mark <= 3'd0;
      state.line_prefix_ok   <= 1'b1;
      state.line_has_text    <= 1'b0;
      state.line_is_comment  <= 1'b0;
      state.after_open       <= 3'd0;
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  // Input register: load on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= text_byte;
      s1_last <= file_last;
    end
  end

  // Result register: fill on a line end, drain when the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && emit) begin
      line_class <= class_next;
      file_end   <= s1_last;
    end
  end

endmodule

// ===== hw/rtl/slc_checker.sv =====
// Port-level checks for source_line_classifier, attached by bind.
// Depends on slc_pkg.
module slc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [7:0]                    text_byte,
  input logic                          file_last,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    line_class,
  input logic                          file_end,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_class) && $stable(file_end))
    else $error("stalled result changed");

  // Only defined class codes leave the block.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_class == slc_pkg::CLASS_BLANK) ||
                  (line_class == slc_pkg::CLASS_COMMENT) ||
                  (line_class == slc_pkg::CLASS_CODE))
    else $error("undefined line class");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An accepted line-ending byte yields a result if the output is free while it sits in the input register.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && ((text_byte == slc_pkg::BYTE_NEWLINE) || file_last))
      ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("line end produced no result");

  // A configuration write is never held off.
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind source_line_classifier slc_checker u_slc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for source_line_classifier: byte stream in, line class out.
// Depends on slc_pkg and the RTL only; holds its own line classifier model.
`timescale 1ns / 1ps

module testbench;
  import slc_pkg::*;

  localparam int RUN_LIMIT    = 400000;  // cycles before the watchdog gives up
  localparam int DRAIN_CYCLES = 8;       // input and result registers plus margin for non-ending bytes
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int PRINT_CAP    = 100;
  localparam logic [63:0] MARK_ALPHABET = "/*#-{};!";

  typedef struct packed {
    logic [1:0] cls;
    logic       fe;
  } line_result_t;

  // One directed transaction; known rows carry a hand-computed result.
  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       known;
    logic [1:0] cls;
    logic       fe;
  } stim_row_t;

  // Directed text under the reset markers ("//", "/*", "*/").
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{8'h0A, 1'b0, 1'b1, CLASS_BLANK,   1'b0},  // empty line
    '{8'h2F, 1'b0, 1'b0, CLASS_BLANK,   1'b0},  // "//" line comment
    '{8'h2F, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h0A, 1'b0, 1'b1, CLASS_COMMENT, 1'b0},
    '{8'h20, 1'b0, 1'b0, CLASS_BLANK,   1'b0},  // " x" plain code
    '{8'h78, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h0A, 1'b0, 1'b1, CLASS_CODE,    1'b0},
    '{8'h2F, 1'b0, 1'b0, CLASS_BLANK,   1'b0},  // "/*" opens a block
    '{8'h2A, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h0A, 1'b0, 1'b1, CLASS_COMMENT, 1'b0},
    '{8'h61, 1'b0, 1'b0, CLASS_BLANK,   1'b0},  // "a*/" inside the block, closes it
    '{8'h2A, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h2F, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h0A, 1'b0, 1'b1, CLASS_COMMENT, 1'b0},
    '{8'h00, 1'b0, 1'b0, CLASS_BLANK,   1'b0},  // zero byte stops the line
    '{8'h78, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h0A, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h78, 1'b0, 1'b0, CLASS_BLANK,   1'b0},  // "x/*y*/" code then a closed block
    '{8'h2F, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h2A, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h79, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h2A, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h2F, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'h0A, 1'b0, 1'b0, CLASS_BLANK,   1'b0},
    '{8'hFF, 1'b1, 1'b1, CLASS_CODE,    1'b1}   // top byte value ends the file
  };

  // Clock, reset and DUT ports; every input starts at a known value.
  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           text_byte = 8'h00;
  logic                 file_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           line_class;
  logic                 file_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  source_line_classifier dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .file_last  (file_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_class (line_class),
    .file_end   (file_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Line results still owed by the DUT, oldest first.
  line_result_t pending_lines[$];
  int           error_count    = 0;
  int           bytes_sent     = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 7;
  int           recv_stall_pct = 71;
  bit           pressure_go    = 1'b0;

  // ---------------------------------------------------------------------------
  // Line classifier model: marker registers and per-line scan state.
  // ---------------------------------------------------------------------------
  logic [31:0] ln_mark, op_mark, cl_mark;
  logic [2:0]  ln_len, op_len, cl_len;
  logic [31:0] win;           // last four bytes, newest in the top byte
  logic        in_cmt_block;  // inside a block comment, carries across lines
  phase_t      phase;
  logic [2:0]  region_cnt;    // bytes in the current search region, saturating
  logic [2:0]  open_cnt;      // bytes since the open marker, saturating
  logic        pfx_ok;        // line marker may still match
  logic        has_text;
  logic        is_cmt;

  // Clamp a marker length to what the window can hold.
  function automatic logic [2:0] eff_len(input logic [2:0] v);
    int lim;
    lim = (MARK_BYTES < 4) ? MARK_BYTES : 4;
    return (int'(v) > lim) ? 3'(lim) : v;
  endfunction

  function automatic logic [2:0] bump(input logic [2:0] x);
    return (x == 3'd7) ? x : x + 3'd1;
  endfunction

  // True when the newest len window bytes equal the first len marker bytes.
  function automatic logic window_ends_with(input logic [31:0] mark, input logic [2:0] len);
    int n;
    n = int'(len);
    for (int i = 0; i < n; i++)
      if (win[8*(4-n+i) +: 8] != mark[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the line marker compare; true when the marker completes.
  function automatic logic line_mark_step(input logic [7:0] b);
    logic [2:0] k;
    logic [2:0] ll;
    k          = region_cnt;
    ll         = eff_len(ln_len);
    region_cnt = bump(k);
    if (ll == 3'd0) begin
      pfx_ok = 1'b0;
      return 1'b0;
    end
    if (pfx_ok && (k < ll)) begin
      if (b != ln_mark[8*k +: 8]) pfx_ok = 1'b0;
      else if (k + 3'd1 == ll) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic close_seen(input logic [2:0] count);
    logic [2:0] cl;
    cl = eff_len(cl_len);
    if (cl == 3'd0) cl = 3'd1;
    return (count >= cl) && window_ends_with(cl_mark, cl);
  endfunction

  function automatic void begin_region();
    phase      = PH_SCAN;
    region_cnt = 3'd0;
    pfx_ok     = 1'b1;
  endfunction

  function automatic void scan_step(input logic [7:0] b);
    logic [2:0] ol;
    if (line_mark_step(b)) begin
      is_cmt = 1'b1;
      phase  = PH_DONE;
      return;
    end
    ol = eff_len(op_len);
    if ((ol != 3'd0) && (region_cnt >= ol) && window_ends_with(op_mark, ol)) begin
      is_cmt   = 1'b1;
      open_cnt = 3'd0;
      // the line marker may still win while its prefix matches
      if (pfx_ok) begin
        phase = PH_HOLD;
      end else begin
        phase        = PH_OPEN;
        in_cmt_block = 1'b1;
      end
    end
  endfunction

  function automatic void hold_step(input logic [7:0] b);
    if (line_mark_step(b)) begin
      phase = PH_DONE;
      return;
    end
    open_cnt = bump(open_cnt);
    if (close_seen(open_cnt)) begin
      phase = PH_DONE;
    end else if (!pfx_ok) begin
      phase        = PH_OPEN;
      in_cmt_block = 1'b1;
    end
  endfunction

  function automatic void close_step();
    region_cnt = bump(region_cnt);
    if (close_seen(region_cnt)) begin
      in_cmt_block = 1'b0;
      begin_region();
    end
  endfunction

  function automatic void settle_line();
    if (phase == PH_HOLD) in_cmt_block = 1'b1;
    phase = PH_DONE;
  endfunction

  // Feed one byte; true with res filled when the byte ends a line.
  function automatic logic classify_byte(input logic [7:0] b, input logic last,
                                         output line_result_t res);
    win = {b, win[31:8]};
    if (phase == PH_LEAD) begin
      if (b == BYTE_NUL) begin
        phase = PH_DONE;
      end else if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))) begin
        has_text = 1'b1;
        if (in_cmt_block) begin
          is_cmt     = 1'b1;
          phase      = PH_CLOSE;
          region_cnt = 3'd0;
          close_step();
        end else begin
          begin_region();
          scan_step(b);
        end
      end
    end else if (phase != PH_DONE) begin
      if (b == BYTE_NUL) begin
        settle_line();
      end else begin
        case (phase)
          PH_CLOSE: close_step();
          PH_SCAN:  scan_step(b);
          PH_HOLD:  hold_step(b);
          PH_OPEN: begin
            open_cnt = bump(open_cnt);
            if (close_seen(open_cnt)) begin
              in_cmt_block = 1'b0;
              phase        = PH_DONE;
            end
          end
          default: phase = PH_DONE;
        endcase
      end
    end

    if ((b != BYTE_NEWLINE) && !last) return 1'b0;

    settle_line();
    res.cls = !has_text ? CLASS_BLANK : (is_cmt ? CLASS_COMMENT : CLASS_CODE);
    res.fe  = last;
    phase      = PH_LEAD;
    region_cnt = 3'd0;
    pfx_ok     = 1'b1;
    has_text   = 1'b0;
    is_cmt     = 1'b0;
    open_cnt   = 3'd0;
    if (last) begin
      in_cmt_block = 1'b0;
      win          = '0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold reset once, at the start of the run.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Abort the run if it runs far past the slowest correct schedule.
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d line results outstanding",
             cycle_count, pending_lines.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    bit pressure_seen;
    hold_left     = 0;
    pressure_seen = 1'b0;
    forever begin
      @(posedge clk);
      // Start the long hold-off once; the sender keeps pushing meanwhile.
      if (pressure_go && !pressure_seen) begin
        pressure_seen = 1'b1;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    line_result_t want;
    if (!rst && (out_valid === 1'b1) && (out_stall == 1'b0)) begin
      if (pending_lines.size() == 0) begin
        report_mismatch($sformatf("unexpected result class=%0d end=%0b",
                                  line_class, file_end));
      end else begin
        want = pending_lines.pop_front();
        if (line_class !== want.cls)
          report_mismatch($sformatf("line_class got %0d want %0d", line_class, want.cls));
        if (file_end !== want.fe)
          report_mismatch($sformatf("file_end got %0b want %0b", file_end, want.fe));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until accepted, then predict its line result.
  // A known row replaces the model's result with the hand-computed one.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic known = 1'b0, input line_result_t typed_res = '0);
    line_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    file_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (classify_byte(b, last, res)) pending_lines.push_back(known ? typed_res : res);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(4))
      0:       return 8'h09;
      1:       return 8'h0B;
      2:       return 8'h0C;
      3:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  // Send a marker, now and then cut short to exercise partial matches.
  task automatic send_marker(input logic [31:0] mark, input logic [2:0] len);
    int n;
    n = int'(eff_len(len));
    if (n == 0) n = 1;
    if ($urandom_range(7) == 0) n = $urandom_range(1, n);
    for (int i = 0; i < n; i++) send_byte(mark[8*i +: 8], 1'b0);
  endtask

  // Send one line built from the current markers, or now and then a line of noise.
  task automatic send_line();
    int kind;
    int ntok;
    if ($urandom_range(9) == 0) begin
      ntok = $urandom_range(1, 10);
      repeat (ntok) send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(BYTE_NEWLINE, 1'b0);
      return;
    end
    repeat ($urandom_range(3)) send_byte(pick_space(), 1'b0);
    ntok = $urandom_range(6);
    repeat (ntok) begin
      kind = $urandom_range(99);
      if (kind < 15)      send_marker(ln_mark, ln_len);
      else if (kind < 30) send_marker(op_mark, op_len);
      else if (kind < 45) send_marker(cl_mark, cl_len);
      else if (kind < 60) send_byte(8'({cl_mark, op_mark, ln_mark} >> (8 * $urandom_range(11))),
                                    1'b0);
      else if (kind < 85) send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      else if (kind < 95) send_byte(pick_space(), 1'b0);
      else if (kind < 97) send_byte(BYTE_NUL, 1'b0);
      else                send_byte(8'($urandom_range(255)), 1'b0);
    end
    // End the file on roughly one line in twelve, on a newline or a plain byte.
    if ($urandom_range(11) == 0)
      send_byte($urandom_range(1) ? BYTE_NEWLINE : 8'($urandom_range(8'h21, 8'h7E)), 1'b1);
    else
      send_byte(BYTE_NEWLINE, 1'b0);
  endtask

  // Drop valid, wait for every owed result, then let the pipe empty.
  task automatic let_block_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_bytes);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) send_line();
    let_block_settle();
  endtask

  // ---------------------------------------------------------------------------
  // Configuration side
  // ---------------------------------------------------------------------------

  // Write one register; valid stays up so back-to-back writes need no re-raise.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LINE_MARK:      ln_mark = data;
      REG_LINE_MARK_LEN:  ln_len  = data[2:0];
      REG_OPEN_MARK:      op_mark = data;
      REG_OPEN_MARK_LEN:  op_len  = data[2:0];
      REG_CLOSE_MARK:     cl_mark = data;
      REG_CLOSE_MARK_LEN: cl_len  = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_markers(input logic [31:0] lm, input logic [2:0] ll,
                             input logic [31:0] om, input logic [2:0] ol,
                             input logic [31:0] cm, input logic [2:0] cll);
    write_reg(REG_LINE_MARK,      lm);
    write_reg(REG_LINE_MARK_LEN,  32'(ll));
    write_reg(REG_OPEN_MARK,      om);
    write_reg(REG_OPEN_MARK_LEN,  32'(ol));
    write_reg(REG_CLOSE_MARK,     cm);
    write_reg(REG_CLOSE_MARK_LEN, 32'(cll));
    cfg_valid <= 1'b0;
  endtask

  // Marker drawn mostly from a few punctuation bytes so markers collide often.
  function automatic logic [31:0] rand_mark();
    logic [31:0] m;
    for (int i = 0; i < 4; i++)
      m[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                             : MARK_ALPHABET[8*$urandom_range(7) +: 8];
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Model state after reset: C-style markers, nothing open.
    ln_mark      = 32'h0000_2F2F;
    ln_len       = 3'd2;
    op_mark      = 32'h0000_2A2F;
    op_len       = 3'd2;
    cl_mark      = 32'h0000_2F2A;
    cl_len       = 3'd2;
    win          = '0;
    in_cmt_block = 1'b0;
    phase        = PH_LEAD;
    region_cnt   = 3'd0;
    open_cnt     = 3'd0;
    pfx_ok       = 1'b1;
    has_text     = 1'b0;
    is_cmt       = 1'b0;

    @(posedge clk);
    while (rst) @(posedge clk);

    // Sender sparse idles, receiver stalls most cycles.
    send_idle_pct  = 7;
    recv_stall_pct <= 71;

    // Walk the directed table under the reset markers.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_byte(DIRECTED_ROWS[i].text, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].known,
                line_result_t'({DIRECTED_ROWS[i].cls, DIRECTED_ROWS[i].fe}));
    let_block_settle();

    // Random markers with any length, clamped and zero lengths included.
    set_markers(rand_mark(), 3'($urandom_range(7)), rand_mark(), 3'($urandom_range(7)),
                rand_mark(), 3'($urandom_range(7)));
    run_phase(350);

    // Extremes: all-ones line marker at oversize length, all-zero open marker,
    // all-ones close marker at zero length.
    set_markers(32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd4, 32'hFFFF_FFFF, 3'd0);
    run_phase(200);

    // Swap roles: sender idles most cycles, receiver rarely stalls.
    send_idle_pct  = 71;
    recv_stall_pct <= 7;

    // Line marker "/*/" overlaps open marker "/*": drive the undecided phase.
    set_markers(32'h002F_2A2F, 3'd3, 32'h0000_2A2F, 3'd2, 32'h0000_2F2A, 3'd2);
    run_phase(350);

    // Everything disabled: no comment can start, so only blank and code lines once an open block ends with its file.
    set_markers(32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0);
    run_phase(150);

    // No idling on either side; one long receiver hold-off backs up the input.
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    set_markers(rand_mark(), 3'($urandom_range(1, 4)), rand_mark(), 3'($urandom_range(1, 4)),
                rand_mark(), 3'($urandom_range(1, 4)));
    pressure_go <= 1'b1;
    run_phase(350);

    set_markers(rand_mark(), 3'($urandom_range(4)), rand_mark(), 3'($urandom_range(1, 4)),
                rand_mark(), 3'($urandom_range(1, 4)));
    run_phase(350);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
